[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/ctg_pkg.sv]
// ----------------------------------------------------------------------------
// ctg_pkg
// Shared constants, codes and types of the cubic trajectory generator.
// ----------------------------------------------------------------------------
package ctg_pkg;

    // default sizes
    localparam int DEF_POS_WIDTH   = 32;
    localparam int DEF_COUNT_WIDTH = 16;

    // fixed-point formats: u is Q0.16, blend weight h is 0..1.0 in 17 bits
    localparam int FRAC_W = 16;
    localparam int H_W    = FRAC_W + 1;

    // input word kinds
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_POSE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    // result word kinds
    localparam logic RES_ACK = 1'b0;
    localparam logic RES_SET = 1'b1;

    // divider result
    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } t_div_out;

    // blend weight result
    typedef struct packed {
        logic           valid;
        logic [H_W-1:0] h;
    } t_wgt_out;

endpackage

[src/ctg_if.sv]
// ----------------------------------------------------------------------------
// ctg_if
// Valid/ready channels of the trajectory generator: command words in,
// acknowledge and setpoint words out.
// ----------------------------------------------------------------------------
interface ctg_in_if #(
    parameter int POS_WIDTH   = ctg_pkg::DEF_POS_WIDTH,
    parameter int COUNT_WIDTH = ctg_pkg::DEF_COUNT_WIDTH
);
    import ctg_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [KIND_W-1:0]           kind;
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [POS_WIDTH-1:0] pos_z;
    logic [COUNT_WIDTH-1:0]      duration_ticks;

    modport source (
        output valid, kind, pos_x, pos_y, pos_z, duration_ticks,
        input  ready
    );
    modport sink (
        input  valid, kind, pos_x, pos_y, pos_z, duration_ticks,
        output ready
    );
endinterface

interface ctg_out_if #(
    parameter int POS_WIDTH = ctg_pkg::DEF_POS_WIDTH
);
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic                        accepted;
    logic signed [POS_WIDTH-1:0] set_x;
    logic signed [POS_WIDTH-1:0] set_y;
    logic signed [POS_WIDTH-1:0] set_z;
    logic                        last;

    modport source (
        output valid, result_kind, accepted, set_x, set_y, set_z, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, accepted, set_x, set_y, set_z, last,
        output ready
    );
endinterface

[src/ctg_div.sv]
// ----------------------------------------------------------------------------
// ctg_div
// Restoring divider for the path phase u = floor(k * 2^16 / N), k < N.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctg_div #(
    parameter int COUNT_WIDTH = ctg_pkg::DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [COUNT_WIDTH-1:0] i_k,
    input  logic [COUNT_WIDTH-1:0] i_n,
    output ctg_pkg::t_div_out      o_div
);
    import ctg_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [COUNT_WIDTH-1:0] r_rem;
    logic [COUNT_WIDTH-1:0] r_n;
    logic [FRAC_W-1:0]      r_q;

    logic [COUNT_WIDTH:0]   shifted;
    logic                   ge;
    logic [COUNT_WIDTH-1:0] n_rem;

    // one trial subtraction; remainder stays below N
    always_comb begin
        shifted = {r_rem, 1'b0};
        ge      = shifted >= {1'b0, r_n};
        n_rem   = ge ? COUNT_WIDTH'(shifted - {1'b0, r_n}) : shifted[COUNT_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_W);
                r_rem  <= i_k;
                r_n    <= i_n;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[FRAC_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_div.done = r_done;
    assign o_div.quot = r_q;

endmodule

[src/ctg_weight.sv]
// ----------------------------------------------------------------------------
// ctg_weight
// Blend weight h = round((3u^2*2^16 - 2u^3) / 2^32), 0..65536.
// Three stages: u^2, u^3, combine and round.
// ----------------------------------------------------------------------------
module ctg_weight (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctg_pkg::t_div_out i_div,
    output ctg_pkg::t_wgt_out o_wgt
);
    import ctg_pkg::*;

    localparam int U2_W = 2 * FRAC_W;
    localparam int U3_W = 3 * FRAC_W;
    localparam int S_W  = 3 * FRAC_W + 3;

    logic [2:0]        r_v;
    logic [FRAC_W-1:0] r_u1;
    logic [U2_W-1:0]   r_u2;
    logic [U2_W-1:0]   r_u2d;
    logic [U3_W-1:0]   r_u3;
    logic [H_W-1:0]    r_h;

    logic [S_W-1:0]    a;
    logic [S_W-1:0]    sum;

    // 3*u^2*2^16 - 2*u^3 + 2^31, never negative for u < 1
    always_comb begin
        a   = S_W'({r_u2d, {FRAC_W{1'b0}}});
        sum = (a << 1) + a - (S_W'(r_u3) << 1) + (S_W'(1) << (U2_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_div.done};
        end
        r_u1  <= i_div.quot;
        r_u2  <= U2_W'(i_div.quot) * U2_W'(i_div.quot);
        r_u3  <= U3_W'(r_u2) * U3_W'(r_u1);
        r_u2d <= r_u2;
        r_h   <= sum[U2_W +: H_W];
    end

    assign o_wgt.valid = r_v[2];
    assign o_wgt.h     = r_h;

endmodule

[src/ctg_lane.sv]
// ----------------------------------------------------------------------------
// ctg_lane
// One axis: p = s + (f - s) * h, step formed on the magnitude and rounded
// half away from zero. Three stages.
// ----------------------------------------------------------------------------
module ctg_lane #(
    parameter int POS_WIDTH = ctg_pkg::DEF_POS_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ctg_pkg::t_wgt_out           i_wgt,
    input  logic signed [POS_WIDTH-1:0] i_s,
    input  logic signed [POS_WIDTH-1:0] i_f,
    output logic                        o_valid,
    output logic signed [POS_WIDTH-1:0] o_pos
);
    import ctg_pkg::*;

    localparam int MAG_W = POS_WIDTH + 1;
    localparam int HI_W  = MAG_W - FRAC_W;
    localparam int PH_W  = HI_W + H_W;
    localparam int PL_W  = FRAC_W + H_W;
    localparam int Q_W   = PH_W + 1;

    logic [2:0]                  r_v;
    logic                        r_neg1;
    logic                        r_neg2;
    logic [MAG_W-1:0]            r_mag;
    logic [H_W-1:0]              r_h1;
    logic signed [POS_WIDTH-1:0] r_s1;
    logic signed [POS_WIDTH-1:0] r_s2;
    logic [PH_W-1:0]             r_ph;
    logic [PL_W-1:0]             r_pl;
    logic signed [POS_WIDTH-1:0] r_pos;

    logic signed [MAG_W-1:0]     d;
    logic [MAG_W-1:0]            n_mag;
    logic [PL_W:0]               rnd;
    logic [Q_W-1:0]              q;
    logic signed [POS_WIDTH-1:0] step;
    logic signed [POS_WIDTH-1:0] n_pos;

    // difference and its magnitude
    always_comb begin
        d     = MAG_W'(i_f) - MAG_W'(i_s);
        n_mag = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
    end

    // high product plus rounded low product; step never exceeds |f - s|
    always_comb begin
        rnd   = (PL_W + 1)'(r_pl) + ((PL_W + 1)'(1) << (FRAC_W - 1));
        q     = Q_W'(r_ph) + Q_W'(rnd[PL_W:FRAC_W]);
        step  = $signed(q[POS_WIDTH-1:0]);
        n_pos = r_neg2 ? r_s2 - step : r_s2 + step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_wgt.valid};
        end
        r_neg1 <= d[MAG_W-1];
        r_mag  <= n_mag;
        r_h1   <= i_wgt.h;
        r_s1   <= i_s;
        r_ph   <= PH_W'(r_mag[MAG_W-1:FRAC_W]) * PH_W'(r_h1);
        r_pl   <= PL_W'(r_mag[FRAC_W-1:0]) * PL_W'(r_h1);
        r_neg2 <= r_neg1;
        r_s2   <= r_s1;
        r_pos  <= n_pos;
    end

    assign o_valid = r_v[2];
    assign o_pos   = r_pos;

endmodule

[src/cubic_trajectory_generator.sv]
// ----------------------------------------------------------------------------
// cubic_trajectory_generator
// Tick: setpoint word after acceptance via a 16-step divider, three weight
// stages, three lane stages and two control steps; next word back in idle.
// Move: acknowledge word via the emit state, next word back in idle. Pose,
// idle tick: no word. A waiting output word stalls emit state and input.
// Synchronous active-low reset: idle, no move, pose and target cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cubic_trajectory_generator #(
    parameter int POS_WIDTH   = ctg_pkg::DEF_POS_WIDTH,
    parameter int COUNT_WIDTH = ctg_pkg::DEF_COUNT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctg_in_if.sink      i_in,
    ctg_out_if.source   o_out
);
    import ctg_pkg::*;

    localparam int NUM_AX = 3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

    t_state                      r_state;
    logic signed [POS_WIDTH-1:0] r_pose   [NUM_AX];
    logic signed [POS_WIDTH-1:0] r_target [NUM_AX];
    logic [COUNT_WIDTH-1:0]      r_len;
    logic [COUNT_WIDTH-1:0]      r_tick;
    logic                        r_moving;
    logic                        r_is_tick;
    logic                        r_ack_ok;
    logic                        r_fin;

    logic                        r_o_valid;
    logic                        r_o_kind;
    logic                        r_o_acc;
    logic signed [POS_WIDTH-1:0] r_o_x;
    logic signed [POS_WIDTH-1:0] r_o_y;
    logic signed [POS_WIDTH-1:0] r_o_z;
    logic                        r_o_last;

    logic                        accept;
    logic                        out_free;
    logic                        move_ok;
    logic                        tick_go;
    logic                        tick_fin;
    logic                        div_start;
    t_div_out                    div;
    t_wgt_out                    wgt;
    logic                        lane_valid [NUM_AX];
    logic signed [POS_WIDTH-1:0] lane_pos   [NUM_AX];

    // handshake and per-word decisions
    always_comb begin
        i_in.ready = i_rst_n && (r_state == S_IDLE);
        accept     = i_in.valid && i_in.ready;
        out_free   = !r_o_valid || o_out.ready;
        move_ok    = !r_moving && (i_in.pos_z > 0);
        tick_go    = r_moving && (r_len != '0) && (r_tick < r_len);
        tick_fin   = ((COUNT_WIDTH + 1)'(r_tick) + 1'b1) == {1'b0, r_len};
        div_start  = accept && (i_in.kind == KIND_TICK) && tick_go;
    end

    // phase u = k / N
    ctg_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_k     (r_tick),
        .i_n     (r_len),
        .o_div   (div)
    );

    // blend weight h(u)
    ctg_weight u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_div   (div),
        .o_wgt   (wgt)
    );

    // one lane per axis
    for (genvar g = 0; g < NUM_AX; g++) begin : g_lane
        ctg_lane #(
            .POS_WIDTH (POS_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wgt   (wgt),
            .i_s     (r_pose[g]),
            .i_f     (r_target[g]),
            .o_valid (lane_valid[g]),
            .o_pos   (lane_pos[g])
        );
    end

    // control, stores and output word register (lanes merge here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_tick    <= '0;
            r_moving  <= 1'b0;
            r_o_valid <= 1'b0;
            for (int a = 0; a < NUM_AX; a++) begin
                r_pose[a]   <= '0;
                r_target[a] <= '0;
            end
        end else begin
            // word taken and nothing new loaded this cycle
            if (r_o_valid && o_out.ready && (r_state != S_EMIT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_in.kind)
                            KIND_POSE: begin
                                r_pose[0] <= i_in.pos_x;
                                r_pose[1] <= i_in.pos_y;
                                r_pose[2] <= i_in.pos_z;
                            end
                            KIND_MOVE: begin
                                if (move_ok) begin
                                    r_target[0] <= i_in.pos_x;
                                    r_target[1] <= i_in.pos_y;
                                    r_target[2] <= i_in.pos_z;
                                    r_len       <= i_in.duration_ticks;
                                    r_tick      <= '0;
                                    r_moving    <= (i_in.duration_ticks != '0);
                                end
                                r_ack_ok  <= move_ok;
                                r_is_tick <= 1'b0;
                                r_state   <= S_EMIT;
                            end
                            KIND_TICK: begin
                                if (tick_go) begin
                                    r_fin     <= tick_fin;
                                    r_tick    <= r_tick + 1'b1;
                                    r_is_tick <= 1'b1;
                                    r_state   <= S_CALC;
                                    if (tick_fin) begin
                                        r_moving <= 1'b0;
                                    end
                                end else begin
                                    r_moving <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CALC: begin
                    if (lane_valid[0]) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        if (r_is_tick) begin
                            r_o_kind <= RES_SET;
                            r_o_acc  <= 1'b0;
                            r_o_x    <= lane_pos[0];
                            r_o_y    <= lane_pos[1];
                            r_o_z    <= lane_pos[2];
                            r_o_last <= r_fin;
                        end else begin
                            r_o_kind <= RES_ACK;
                            r_o_acc  <= r_ack_ok;
                            r_o_x    <= '0;
                            r_o_y    <= '0;
                            r_o_z    <= '0;
                            r_o_last <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output word
    assign o_out.valid       = r_o_valid;
    assign o_out.result_kind = r_o_kind;
    assign o_out.accepted    = r_o_acc;
    assign o_out.set_x       = r_o_x;
    assign o_out.set_y       = r_o_y;
    assign o_out.set_z       = r_o_z;
    assign o_out.last        = r_o_last;

    // checks
    `ASSERT_IMPLIES(a_lanes_aligned, i_clk, i_rst_n, lane_valid[0], lane_valid[1] && lane_valid[2])
    `ASSERT_IMPLIES(a_move_bounds, i_clk, i_rst_n, r_moving, (r_len != '0) && (r_tick < r_len))
    `ASSERT_IMPLIES(a_weight_max, i_clk, i_rst_n, wgt.valid, wgt.h <= (H_W'(1) << FRAC_W))
    `ASSERT_NEXT(a_ack_emit, i_clk, i_rst_n, accept && (i_in.kind == KIND_MOVE), r_state == S_EMIT)

endmodule
